[hdl/atm_pkg.sv]
// Shared types and constants for the trimmed-mean calibration block.
package atm_pkg;

    localparam int CODE_W    = 16;
    localparam int MV_W      = 12;
    localparam int SUM_W     = 18;
    localparam int VOLT_W    = 16;
    localparam int CH_TOTAL  = 8;
    localparam int CH_REF_LOW  = 0;
    localparam int CH_REF_HIGH = 4;
    localparam int NUM_MEAS  = 6;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_REF_LOW_MV  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REF_HIGH_MV = 1'd1;

    localparam logic [11:0] REF_LOW_MV_RST  = 12'd420;
    localparam logic [11:0] REF_HIGH_MV_RST = 12'd1653;

    // Clamp applied to the rounded quotient before the offset is added.
    localparam logic [16:0] Q_CLAMP = 17'd100000;

    typedef struct packed {
        logic [CODE_W-1:0] ref_low_code;
        logic [CODE_W-1:0] chan_a1_code;
        logic [CODE_W-1:0] chan_a2_code;
        logic [CODE_W-1:0] chan_a3_code;
        logic [CODE_W-1:0] ref_high_code;
        logic [CODE_W-1:0] chan_b1_code;
        logic [CODE_W-1:0] chan_b2_code;
        logic [CODE_W-1:0] chan_b3_code;
    } in_item_t;

    typedef struct packed {
        logic [SUM_W-1:0]         ref_low_sum;
        logic [SUM_W-1:0]         ref_high_sum;
        logic signed [VOLT_W-1:0] volt_a1;
        logic signed [VOLT_W-1:0] volt_a2;
        logic signed [VOLT_W-1:0] volt_a3;
        logic signed [VOLT_W-1:0] volt_b1;
        logic signed [VOLT_W-1:0] volt_b2;
        logic signed [VOLT_W-1:0] volt_b3;
        logic                     cal_invalid;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic store;      // write the accepted set into the store
        logic rank_start; // clear rank counters for a new candidate
        logic rank_step;  // compare the candidate against one sample
        logic rank_done;  // add the candidate if its rank is in the window
        logic cal_start;  // latch the reference sums and the reference span
        logic div_start;  // start the divider for the current channel
        logic cal_finish; // write the rounded voltage of the current channel
        logic out_load;   // move the finished result to the output register
    } atm_cmd_t;

    typedef struct packed {
        logic div_busy;
    } atm_sts_t;

    // Map of measured-channel slot to input channel.
    function automatic logic [2:0] meas_chan(input logic [2:0] k);
        logic [2:0] r;
        case (k)
            3'd0: r = 3'd1;
            3'd1: r = 3'd2;
            3'd2: r = 3'd3;
            3'd3: r = 3'd5;
            3'd4: r = 3'd6;
            default: r = 3'd7;
        endcase
        return r;
    endfunction

endpackage

[hdl/adc_trimmed_mean_two_point_cal_top.sv]
// Each accepted request is written into the sample memory one channel a cycle. The last
// set of a burst starts the end-of-burst work: every stored sample is ranked against its
// channel by a scan of the memory port, then six calibrated voltages come from a
// restoring divider. The result waits in an output register; while the burst work
// runs, no request is accepted.
module adc_trimmed_mean_two_point_cal_top
    import atm_pkg::*;
#(
    parameter int BURST_LEN    = 10,
    parameter int KEEP_FIRST   = 3,
    parameter int KEEP_COUNT   = 4,
    parameter int NUM_CHANNELS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MV_W-1:0]      cfg_data
);

    localparam int IDX_W = $clog2(BURST_LEN + 1);
    localparam int ACC_W = CODE_W + $clog2(KEEP_COUNT + 1);

    atm_cmd_t cmd;
    atm_sts_t sts;
    logic [IDX_W-1:0] wr_idx, cand_idx, scan_idx;
    logic [2:0] ch_sel, meas_sel;
    logic [MV_W-1:0] ref_low_mv_reg, ref_high_mv_reg;
    in_item_t in_hold_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_low_mv_reg  <= REF_LOW_MV_RST;
            ref_high_mv_reg <= REF_HIGH_MV_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_REF_LOW_MV:  ref_low_mv_reg  <= cfg_data;
                REG_REF_HIGH_MV: ref_high_mv_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) in_hold_reg <= s_data;
    end

    atm_ctrl #(.BURST_LEN(BURST_LEN), .IDX_W(IDX_W)) u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
        .sts, .cmd, .wr_idx, .ch_sel, .cand_idx, .scan_idx, .meas_sel
    );

    atm_datapath #(
        .BURST_LEN(BURST_LEN), .KEEP_FIRST(KEEP_FIRST), .KEEP_COUNT(KEEP_COUNT),
        .NUM_CHANNELS(NUM_CHANNELS), .IDX_W(IDX_W), .ACC_W(ACC_W)
    ) u_dp (
        .aclk, .aresetn, .cmd, .sts, .in_item(in_hold_reg), .wr_idx, .ch_sel,
        .cand_idx, .scan_idx, .meas_sel,
        .ref_low_mv(ref_low_mv_reg), .ref_high_mv(ref_high_mv_reg),
        .result(m_data)
    );

endmodule

[hdl/atm_datapath.sv]
// Datapath: sample memory, rank-count trimmed sums and serial calibration divider.
module atm_datapath
    import atm_pkg::*;
#(
    parameter int BURST_LEN    = 10,
    parameter int KEEP_FIRST   = 3,
    parameter int KEEP_COUNT   = 4,
    parameter int NUM_CHANNELS = 8,
    parameter int IDX_W        = 4,
    parameter int ACC_W        = 20
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  atm_cmd_t          cmd,
    output atm_sts_t          sts,
    input  in_item_t          in_item,
    input  logic [IDX_W-1:0]  wr_idx,
    input  logic [2:0]        ch_sel,
    input  logic [IDX_W-1:0]  cand_idx,
    input  logic [IDX_W-1:0]  scan_idx,
    input  logic [2:0]        meas_sel,
    input  logic [MV_W-1:0]   ref_low_mv,
    input  logic [MV_W-1:0]   ref_high_mv,
    output out_item_t         result
);

    localparam int DEPTH  = CH_TOTAL * BURST_LEN;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int NUM_W  = ACC_W + 14;
    localparam int DEN_W  = ACC_W + 1;
    localparam int QW     = NUM_W + 2;
    localparam int DIV_CNT_W = $clog2(QW + 1);

    logic [CODE_W-1:0] mem [DEPTH];
    logic [CODE_W-1:0] codes [CH_TOTAL];
    logic [CODE_W-1:0] cand_reg, samp_reg;
    logic              cand_phase_reg;
    logic [IDX_W:0]    less_reg, less_next, le_reg, le_next;
    logic [ACC_W-1:0]  sums_reg [CH_TOTAL];
    logic [ADDR_W-1:0] rd_addr;
    logic [IDX_W-1:0]  rd_sel;

    assign codes[0] = in_item.ref_low_code;
    assign codes[1] = in_item.chan_a1_code;
    assign codes[2] = in_item.chan_a2_code;
    assign codes[3] = in_item.chan_a3_code;
    assign codes[4] = in_item.ref_high_code;
    assign codes[5] = in_item.chan_b1_code;
    assign codes[6] = in_item.chan_b2_code;
    assign codes[7] = in_item.chan_b3_code;

    // The store is written one channel a cycle; the controller walks ch_sel.
    assign rd_sel  = cmd.rank_start ? cand_idx : scan_idx;
    assign rd_addr = ADDR_W'(32'(ch_sel) * BURST_LEN + 32'(cmd.store ? wr_idx : rd_sel));

    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            mem[rd_addr] <= codes[ch_sel];
        end
        samp_reg <= mem[rd_addr];
    end

    // Rank of the candidate: count of samples below it and of those at or below it.
    // It occupies sorted positions less..le-1.
    always_comb begin
        less_next = less_reg;
        le_next   = le_reg;
        if (cmd.rank_step && !cand_phase_reg) begin
            if (samp_reg < cand_reg)  less_next = less_reg + 1'b1;
            if (samp_reg <= cand_reg) le_next   = le_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cand_phase_reg <= 1'b0;
            less_reg <= '0;
            le_reg   <= '0;
        end else begin
            if (cmd.rank_start) begin
                cand_phase_reg <= 1'b1;
                less_reg <= '0;
                le_reg   <= '0;
            end else begin
                cand_phase_reg <= 1'b0;
                less_reg <= less_next;
                le_reg   <= le_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cand_phase_reg) cand_reg <= samp_reg;
    end

    // Number of kept positions covered by this candidate's run of equal values.
    logic [IDX_W+1:0] lo_b, hi_b, win_hi;
    logic [IDX_W+1:0] mult;
    always_comb begin
        win_hi = (IDX_W+2)'(KEEP_FIRST + KEEP_COUNT);
        if (win_hi > (IDX_W+2)'(BURST_LEN)) win_hi = (IDX_W+2)'(BURST_LEN);
        lo_b = ({1'b0, less_reg} > (IDX_W+2)'(KEEP_FIRST)) ?
               {1'b0, less_reg} : (IDX_W+2)'(KEEP_FIRST);
        hi_b = ({1'b0, le_reg} < win_hi) ? {1'b0, le_reg} : win_hi;
        // Overlap of the run's sorted positions with the kept window.
        mult = (hi_b > lo_b) ? (hi_b - lo_b) : '0;
    end

    // Equal samples each see the same overlap; only the first of the run
    // (its rank index equals less) contributes the whole overlap.
    logic first_of_run_reg;
    logic [IDX_W:0] eq_before_reg;
    logic scan_idx_d_lt;
    logic [IDX_W-1:0] scan_d_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eq_before_reg <= '0;
        end else if (cmd.rank_start) begin
            eq_before_reg <= '0;
        end else if (cmd.rank_step && !cand_phase_reg) begin
            if (samp_reg == cand_reg && scan_idx_d_lt) eq_before_reg <= eq_before_reg + 1'b1;
        end
    end
    always_ff @(posedge aclk) scan_d_reg <= scan_idx;
    assign scan_idx_d_lt = (scan_d_reg < cand_idx);
    assign first_of_run_reg = (eq_before_reg == '0);

    always_ff @(posedge aclk) begin
        for (int c = 0; c < CH_TOTAL; c++) begin
            if (cmd.store && wr_idx == '0 && ch_sel == 3'(c)) sums_reg[c] <= '0;
        end
        if (cmd.rank_done && first_of_run_reg && 32'(ch_sel) < NUM_CHANNELS) begin
            sums_reg[ch_sel] <= sums_reg[ch_sel] + ACC_W'(32'(cand_reg) * 32'(mult));
        end
    end

    // ---- Calibration: num = (s - sl) * (mvh - mvl); q = round(|num| / |den|).
    logic [ACC_W-1:0] sl_reg, sh_reg;
    logic signed [ACC_W+1:0] ds_reg;
    logic signed [MV_W+1:0]  dmv_reg;
    logic [NUM_W-1:0] an_reg;
    logic [DEN_W-1:0] ad_reg;
    logic neg_reg, inval_reg;
    logic [QW-1:0] rem_reg, quo_reg, dvd_reg;
    logic [DIV_CNT_W-1:0] dcnt_reg;
    logic busy_reg;
    logic [1:0] phase_reg;
    logic signed [VOLT_W-1:0] volt_reg [NUM_MEAS];

    assign sts.div_busy = busy_reg;

    logic signed [ACC_W+1:0] den_s;
    assign den_s = $signed({2'b0, sh_reg}) - $signed({2'b0, sl_reg});

    logic signed [NUM_W+1:0] prod;
    assign prod = ds_reg * dmv_reg;

    logic [QW:0] trial;
    assign trial = {rem_reg, dvd_reg[QW-1]} - {{(QW-DEN_W){1'b0}}, ad_reg, 1'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            phase_reg <= '0;
        end else begin
            if (cmd.cal_start) begin
                sl_reg    <= sums_reg[CH_REF_LOW];
                sh_reg    <= sums_reg[CH_REF_HIGH];
                dmv_reg   <= $signed({2'b0, ref_high_mv}) - $signed({2'b0, ref_low_mv});
            end
            if (cmd.div_start) begin
                ds_reg    <= $signed({2'b0, sums_reg[meas_chan(meas_sel)]})
                             - $signed({2'b0, sl_reg});
                busy_reg  <= 1'b1;
                phase_reg <= 2'd1;
            end else if (phase_reg == 2'd1) begin
                // Register the product before the divider consumes it.
                neg_reg   <= (prod < 0) != (den_s < 0);
                an_reg    <= NUM_W'(prod < 0 ? -prod : prod);
                ad_reg    <= DEN_W'(den_s < 0 ? -den_s : den_s);
                phase_reg <= 2'd2;
            end else if (phase_reg == 2'd2) begin
                // Dividend 2|num| + |den|, divisor 2|den|.
                dvd_reg   <= QW'({an_reg, 1'b0}) + QW'(ad_reg);
                rem_reg   <= '0;
                quo_reg   <= '0;
                dcnt_reg  <= DIV_CNT_W'(QW);
                phase_reg <= 2'd3;
            end else if (phase_reg == 2'd3) begin
                if (dcnt_reg == '0) begin
                    busy_reg  <= 1'b0;
                    phase_reg <= '0;
                end else begin
                    if (!trial[QW]) begin
                        rem_reg <= trial[QW-1:0];
                        quo_reg <= {quo_reg[QW-2:0], 1'b1};
                    end else begin
                        rem_reg <= {rem_reg[QW-2:0], dvd_reg[QW-1]};
                        quo_reg <= {quo_reg[QW-2:0], 1'b0};
                    end
                    dvd_reg  <= {dvd_reg[QW-2:0], 1'b0};
                    dcnt_reg <= dcnt_reg - 1'b1;
                end
            end
        end
    end

    logic [16:0] qc;
    logic signed [18:0] v;
    always_comb begin
        qc = (quo_reg > QW'(Q_CLAMP)) ? Q_CLAMP : quo_reg[16:0];
        v  = $signed({7'b0, ref_low_mv}) + (neg_reg ? -$signed({2'b0, qc}) :
             $signed({2'b0, qc}));
        if (v > 19'sd32767) v = 19'sd32767;
        if (v < -19'sd32768) v = -19'sd32768;
    end

    always_ff @(posedge aclk) begin
        if (cmd.cal_start) inval_reg <= (sums_reg[CH_REF_LOW] == sums_reg[CH_REF_HIGH]);
        if (cmd.cal_finish) volt_reg[meas_sel] <= inval_reg ? '0 : VOLT_W'(v);
    end

    function automatic logic [SUM_W-1:0] sat_sum(input logic [ACC_W-1:0] s);
        return (s > ACC_W'(2**SUM_W - 1)) ? '1 : SUM_W'(s);
    endfunction

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            result.ref_low_sum  <= sat_sum(sl_reg);
            result.ref_high_sum <= sat_sum(sh_reg);
            result.volt_a1 <= volt_reg[0];
            result.volt_a2 <= volt_reg[1];
            result.volt_a3 <= volt_reg[2];
            result.volt_b1 <= volt_reg[3];
            result.volt_b2 <= volt_reg[4];
            result.volt_b3 <= volt_reg[5];
            result.cal_invalid <= inval_reg;
        end
    end

endmodule

[hdl/atm_ctrl.sv]
// Controller: sequences storage, ranking, calibration and the output handshake.
module atm_ctrl
    import atm_pkg::*;
#(
    parameter int BURST_LEN = 10,
    parameter int IDX_W     = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  atm_sts_t         sts,
    output atm_cmd_t         cmd,
    output logic [IDX_W-1:0] wr_idx,
    output logic [2:0]       ch_sel,
    output logic [IDX_W-1:0] cand_idx,
    output logic [IDX_W-1:0] scan_idx,
    output logic [2:0]       meas_sel
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_STORE = 4'd1;
    localparam logic [3:0] ST_CAND  = 4'd2;
    localparam logic [3:0] ST_SCAN  = 4'd3;
    localparam logic [3:0] ST_TAIL  = 4'd4;
    localparam logic [3:0] ST_ADD   = 4'd5;
    localparam logic [3:0] ST_CALS  = 4'd6;
    localparam logic [3:0] ST_DIV   = 4'd7;
    localparam logic [3:0] ST_WAIT  = 4'd8;
    localparam logic [3:0] ST_FIN   = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;

    localparam logic [IDX_W-1:0] LAST = IDX_W'(BURST_LEN - 1);

    logic [3:0] state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next, cand_reg, cand_next, scan_reg, scan_next;
    logic [2:0] ch_reg, ch_next, meas_reg, meas_next;
    logic m_valid_reg, m_valid_next;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign wr_idx   = cnt_reg;
    assign ch_sel   = ch_reg;
    assign cand_idx = cand_reg;
    assign scan_idx = scan_reg;
    assign meas_sel = meas_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg; cand_next = cand_reg; scan_next = scan_reg;
        ch_next = ch_reg; meas_next = meas_reg;
        m_valid_next = m_valid_reg;
        cmd = '0;
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_STORE;
                    ch_next = '0;
                end
            end
            ST_STORE: begin
                cmd.store = 1'b1;
                ch_next = ch_reg + 1'b1;
                if (ch_reg == 3'(CH_TOTAL - 1)) begin
                    if (cnt_reg == LAST) begin
                        cnt_next = '0;
                        ch_next = '0;
                        cand_next = '0;
                        state_next = ST_CAND;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CAND: begin
                cmd.rank_start = 1'b1;
                scan_next = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                // Memory read data arrives in the cycle after the address.
                if (scan_reg != '0) cmd.rank_step = 1'b1;
                if (scan_reg == LAST) begin
                    state_next = ST_TAIL;
                end else begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_TAIL: begin
                cmd.rank_step = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD: begin
                cmd.rank_done = 1'b1;
                if (cand_reg == LAST) begin
                    cand_next = '0;
                    if (ch_reg == 3'(CH_TOTAL - 1)) begin
                        state_next = ST_CALS;
                    end else begin
                        ch_next = ch_reg + 1'b1;
                        state_next = ST_CAND;
                    end
                end else begin
                    cand_next = cand_reg + 1'b1;
                    state_next = ST_CAND;
                end
            end
            ST_CALS: begin
                cmd.cal_start = 1'b1;
                meas_next = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_start = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (!sts.div_busy) state_next = ST_FIN;
            end
            ST_FIN: begin
                cmd.cal_finish = 1'b1;
                if (meas_reg == 3'(NUM_MEAS - 1)) begin
                    state_next = ST_OUT;
                end else begin
                    meas_next = meas_reg + 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    ch_next = '0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0; cand_reg <= '0; scan_reg <= '0;
            ch_reg <= '0; meas_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next; cand_reg <= cand_next; scan_reg <= scan_next;
            ch_reg <= ch_next; meas_reg <= meas_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

[hdl/atm_checker.sv]
// Port-level checker for the trimmed-mean calibration block, with its bind.
module atm_port_checker
    import atm_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while storing");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.cal_invalid |-> m_data.volt_a1 == 0 && m_data.volt_b3 == 0)
        else $error("voltages not cleared on invalid calibration");

    a_invalid_eq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.cal_invalid |-> m_data.ref_low_sum == m_data.ref_high_sum)
        else $error("invalid flag without equal sums");

endmodule

bind adc_trimmed_mean_two_point_cal_top atm_port_checker u_chk (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .m_data
);

[sim/atm_checker.sv]
// Checker that watches the block's channels, predicts each burst result and compares it.
module atm_checker
    import atm_pkg::*;
#(
    parameter int BURST_LEN    = 10,
    parameter int KEEP_FIRST   = 3,
    parameter int KEEP_COUNT   = 4,
    parameter int NUM_CHANNELS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  in_item_t             s_data,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  out_item_t            m_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MV_W-1:0]      cfg_data,
    output int                   fail_count,
    output int                   pending_results,
    output int                   results_seen
);

    logic [CODE_W-1:0] set_store [CH_TOTAL][BURST_LEN];
    int                sets_held;
    logic [MV_W-1:0]   low_mv, high_mv;
    out_item_t         burst_results [$];

    function automatic longint channel_sum(int ch);
        logic [CODE_W-1:0] v [BURST_LEN];
        logic [CODE_W-1:0] x;
        longint s;
        int j;
        s = 0;
        for (int i = 0; i < BURST_LEN; i++) v[i] = set_store[ch][i];
        for (int i = 1; i < BURST_LEN; i++) begin
            x = v[i];
            j = i;
            while (j > 0 && v[j-1] > x) begin
                v[j] = v[j-1];
                j--;
            end
            v[j] = x;
        end
        for (int i = KEEP_FIRST; i < KEEP_FIRST + KEEP_COUNT && i < BURST_LEN; i++)
            s += v[i];
        return s;
    endfunction

    function automatic logic [VOLT_W-1:0] cal_volt(longint s, longint sl, longint sh);
        longint num, den, an, ad, q, v;
        bit neg;
        num = (s - sl) * (longint'(high_mv) - longint'(low_mv));
        den = sh - sl;
        neg = (num < 0) != (den < 0);
        an = num < 0 ? -num : num;
        ad = den < 0 ? -den : den;
        q = (2 * an + ad) / (2 * ad);
        if (q > 100000) q = 100000;
        v = longint'(low_mv) + (neg ? -q : q);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[VOLT_W-1:0];
    endfunction

    function automatic out_item_t burst_result();
        longint sums [CH_TOTAL];
        out_item_t r;
        logic [VOLT_W-1:0] volts [NUM_MEAS];
        int meas [NUM_MEAS] = '{1, 2, 3, 5, 6, 7};
        for (int c = 0; c < CH_TOTAL; c++)
            sums[c] = (c < NUM_CHANNELS) ? channel_sum(c) : 0;
        r.ref_low_sum  = sums[CH_REF_LOW] > 262143 ? 18'h3ffff : sums[CH_REF_LOW][SUM_W-1:0];
        r.ref_high_sum = sums[CH_REF_HIGH] > 262143 ? 18'h3ffff : sums[CH_REF_HIGH][SUM_W-1:0];
        r.cal_invalid  = sums[CH_REF_LOW] == sums[CH_REF_HIGH];
        for (int k = 0; k < NUM_MEAS; k++)
            volts[k] = r.cal_invalid ? '0
                     : cal_volt(sums[meas[k]], sums[CH_REF_LOW], sums[CH_REF_HIGH]);
        r.volt_a1 = volts[0]; r.volt_a2 = volts[1]; r.volt_a3 = volts[2];
        r.volt_b1 = volts[3]; r.volt_b2 = volts[4]; r.volt_b3 = volts[5];
        return r;
    endfunction

    always @(posedge aclk) begin
        logic [CODE_W-1:0] codes [CH_TOTAL];
        out_item_t exp_r;
        if (!aresetn) begin
            sets_held    = 0;
            low_mv       = REF_LOW_MV_RST;
            high_mv      = REF_HIGH_MV_RST;
            fail_count   = 0;
            results_seen = 0;
            burst_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_REF_LOW_MV) low_mv = cfg_data;
                else if (cfg_index == REG_REF_HIGH_MV) high_mv = cfg_data;
            end
            if (s_valid && s_ready) begin
                codes = '{s_data.ref_low_code, s_data.chan_a1_code, s_data.chan_a2_code,
                          s_data.chan_a3_code, s_data.ref_high_code, s_data.chan_b1_code,
                          s_data.chan_b2_code, s_data.chan_b3_code};
                for (int c = 0; c < NUM_CHANNELS; c++) set_store[c][sets_held] = codes[c];
                sets_held++;
                if (sets_held >= BURST_LEN) begin
                    sets_held = 0;
                    burst_results.push_back(burst_result());
                end
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (burst_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) $display("Unexpected result %h", m_data);
                end else begin
                    exp_r = burst_results.pop_front();
                    if (exp_r !== m_data) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("Mismatch: expected %p, got %p", exp_r, m_data);
                    end
                end
            end
        end
        pending_results = burst_results.size();
    end

endmodule

[sim/tb_adc_trimmed_mean_two_point_cal_top.sv]
// Stimulus and verdict for the trimmed-mean calibration block.
module tb_adc_trimmed_mean_two_point_cal_top
    import atm_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 20000;

    logic                 aclk = 0;
    logic                 aresetn = 0;
    logic                 s_valid = 0;
    logic                 s_ready;
    in_item_t             s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 0;
    out_item_t            m_data;
    logic                 cfg_valid = 0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_REF_LOW_MV;
    logic [MV_W-1:0]      cfg_data = '0;
    int                   fail_count, pending_results, results_seen;
    int                   send_idle_pct = 0, recv_stall_pct = 0;
    int                   idle_cycles = 0, sets_sent = 0;

    adc_trimmed_mean_two_point_cal_top DUT (.*);

    atm_checker checker_i (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    // The receiver stalls at random, at the rate of the current phase.
    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d results pending", pending_results);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Leaves one idle cycle after the write so that back-to-back calls never
    // assign the valid twice in one step.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [MV_W-1:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    // Valid stays high between back-to-back requests; it drops only while idling and in drain.
    task automatic send_set(in_item_t d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_data  <= d;
        do @(posedge aclk); while (!s_ready);
        sets_sent++;
    endtask

    task automatic drain();
        s_valid <= 0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (1500) @(posedge aclk);
    endtask

    function automatic in_item_t rand_set(int mode, logic [15:0] base);
        in_item_t d;
        d = {$urandom, $urandom, $urandom, $urandom};
        // Mostly realistic sets: references near fixed codes, channels spread out.
        if (mode != 0) begin
            d.ref_low_code  = base + 16'($urandom_range(63));
            d.ref_high_code = base + 16'd20000 + 16'($urandom_range(63));
        end
        return d;
    endfunction

    initial begin
        in_item_t d;
        logic [15:0] base;
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: one burst of extremes at reset calibration.
        for (int i = 0; i < 10; i++) begin
            d = (i % 2) ? '1 : '0;
            d.ref_low_code  = 16'd8000;
            d.ref_high_code = 16'd40000;
            send_set(d);
        end
        // Equal references force the invalid flag.
        for (int i = 0; i < 10; i++) send_set({8{16'h1234 + 16'(i)}});
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin write_reg(REG_REF_LOW_MV, 12'd0);   write_reg(REG_REF_HIGH_MV, 12'd3000); end
                1: begin write_reg(REG_REF_LOW_MV, 12'd3000); write_reg(REG_REF_HIGH_MV, 12'd0); end
                2: begin write_reg(REG_REF_LOW_MV, 12'hfff); write_reg(REG_REF_HIGH_MV, 12'd0); end
                default: begin
                    write_reg(REG_REF_LOW_MV, 12'($urandom));
                    write_reg(REG_REF_HIGH_MV, 12'($urandom));
                end
            endcase
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            for (int b = 0; b < 11; b++) begin
                base = 16'($urandom_range(40000));
                for (int i = 0; i < 10; i++) send_set(rand_set(b % 4, base));
            end
            drain();
        end

        $display("Sent %0d conversion sets, checked %0d burst results over six settings.",
                 sets_sent, results_seen);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[sim.f]
hdl/atm_pkg.sv
hdl/atm_datapath.sv
hdl/atm_ctrl.sv
hdl/adc_trimmed_mean_two_point_cal_top.sv
hdl/atm_checker.sv
sim/atm_checker.sv
sim/tb_adc_trimmed_mean_two_point_cal_top.sv
